>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned Depth  = 32;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned HeldW  = 6;

  typedef enum logic {
    CmdEnq = 1'b0,
    CmdDeq = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [DataW-1:0] item;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // broadcast to every cell in a transfer cycle
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t data;
  } op_t;

endpackage

>>> sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: compares against the incoming priority,
// holds, takes the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk_i,
  input  spq_pkg::op_t   op_i,
  input  logic           occupied_i,
  input  logic           left_stay_i,
  input  spq_pkg::entry_t left_i,
  input  spq_pkg::entry_t right_i,
  output logic           stay_o,
  output spq_pkg::entry_t entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // slot keeps its entry on insert when held and strictly lower
  assign stay_o  = occupied_i && (entry_q.prio < op_i.data.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins && !stay_o) begin
      entry_d = left_stay_i ? op_i.data : left_i;
    end else if (op_i.del) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> sv/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Output: the result is registered on the input transfer and is valid in the next cycle.
// Throughput: one command per cycle if not stalled; every cell compares and
// shifts in parallel, so the chain length does not affect the rate.
// Reset: count and output valid clear; slot contents are not reset.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic signed [31:0]         item_value_i,
  input  logic signed [31:0]         item_priority_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         removed_item_o,
  output spq_pkg::status_e           status_o,
  output logic [spq_pkg::HeldW-1:0]  entries_held_o
);
  import spq_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic signed [DataW-1:0] removed_q, removed_d;
  status_e         status_q, status_d;
  logic [HeldW-1:0] held_q;

  logic  xfer, full, empty;
  op_t   op;
  logic  [Depth-1:0] stay;
  entry_t cell_q [Depth];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign xfer       = in_valid_i && in_ready_o;
  assign full       = (count_q == CntW'(Depth));
  assign empty      = (count_q == '0);

  always_comb begin
    op.ins       = xfer && (command_i == CmdEnq) && !full;
    op.del       = xfer && (command_i == CmdDeq) && !empty;
    op.data.item = item_value_i;
    op.data.prio = item_priority_i;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic   occ;
    logic   lstay;
    entry_t lft, rgt;
    assign occ = (CntW'(i) < count_q);
    if (i == 0) begin : g_first
      assign lstay = 1'b1;
      assign lft   = cell_q[0];
    end else begin : g_mid
      assign lstay = stay[i-1];
      assign lft   = cell_q[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign rgt = cell_q[i];
    end else begin : g_nlast
      assign rgt = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .occupied_i  (occ),
      .left_stay_i (lstay),
      .left_i      (lft),
      .right_i     (rgt),
      .stay_o      (stay[i]),
      .entry_o     (cell_q[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    status_d  = StatOk;
    if (command_i == CmdEnq) begin
      if (full) begin
        status_d = StatFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = StatEmpty;
      end else begin
        removed_d = cell_q[0].item;
        count_d   = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (xfer) begin
        count_q <= count_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      held_q    <= HeldW'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign removed_item_o = removed_q;
  assign status_o       = status_q;
  assign entries_held_o = held_q;

endmodule
